@@ sv/assert_macros.svh @@
// Assertion helpers. Every user has clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfr assertion failed");

// Next-cycle implication.
`define SFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfr assertion failed");

`endif

@@ sv/sfr_pkg.sv @@
package sfr_pkg;

	localparam int CHANNEL_COUNT = 18;
	localparam int FRAME_BYTES   = 25;
	localparam int ANALOG_CH     = 16;
	localparam int RAW_W         = 11;
	localparam int CHAN_BITS     = ANALOG_CH * RAW_W;
	localparam int HOLD_BYTES    = FRAME_BYTES - 1;
	localparam int FQ_DEPTH      = 2;

	localparam logic [7:0]  START_BYTE   = 8'h0F;
	localparam logic [7:0]  END_BYTE     = 8'h00;
	localparam logic [7:0]  GAP_RESET    = 8'd3;
	localparam logic [10:0] DIGITAL_ON   = 11'h7FF;
	localparam logic [11:0] VALUE_OFFSET = 12'd880;

	localparam logic [1:0] KIND_CHAN    = 2'd0;
	localparam logic [1:0] KIND_END_ERR = 2'd1;
	localparam logic [1:0] KIND_LOST    = 2'd2;

	localparam logic REG_GAP_TIMEOUT = 1'b0;
	localparam logic REG_RX_ENABLE   = 1'b1;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  channel_index;
		logic [11:0] value;
		logic        failsafe;
		logic        last;
		logic [31:0] frame_time_ms;
		logic [31:0] good_frames;
		logic [31:0] lost_frames;
		logic [31:0] error_frames;
	} result_t;

	// One classified frame, handed from the assembler to the expander.
	typedef struct packed {
		logic [1:0]           kind;
		logic                 failsafe;
		logic [31:0]          frame_time;
		logic [31:0]          good;
		logic [31:0]          lost;
		logic [31:0]          err;
		logic [CHAN_BITS-1:0] chan_bits;
		logic [1:0]           digital;
	} frame_entry_t;

endpackage

@@ sv/sbus_frame_receiver_unit.sv @@
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------
// input    | push / full        | in_item  (rx_byte, now_ms)
// results  | pop / empty        | result   (kind .. error_frames)
// config   | wr_en (no wait)    | wr_index, wr_data
//
// Input takes one byte per cycle; full rises only when the frame queue
// holds FRAME_QUEUE_DEPTH classified frames.
// A good frame gives 18 results, one per cycle, from the expander's shift
// register; a bad-end or lost frame gives one. The output register sets the
// result rate when pop stalls. Reset: counters, frame time and position
// clear, failsafe sets, gap timeout 3 ms, receive enabled.
module sbus_frame_receiver_unit
	import sfr_pkg::*;
#(
	parameter int FRAME_QUEUE_DEPTH = FQ_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// input transactions
	input  logic       push,
	output logic       full,
	input  in_item_t   in_item,
	// result transactions
	output logic       empty,
	input  logic       pop,
	output result_t    result,
	// configuration writes
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic [7:0] wr_data
);

	logic         take;
	logic         q_push, q_full, q_pop, q_empty;
	frame_entry_t q_entry, q_head;

	// Byte accepted whenever the frame queue has room; bytes that do not
	// complete a frame never touch the queue.
	assign full = q_full;
	assign take = push && !q_full;

	// Front: gap check, start hunt, frame assembly and classification.
	sfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.in_item  (in_item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	// Decoupling queue of classified frames with counter snapshots.
	sfr_queue #(
		.DEPTH (FRAME_QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_entry),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// Back: expands a frame into channel results, or one status result, behind an output register.
	sfr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

@@ sv/sfr_queue.sv @@
`include "assert_macros.svh"

module sfr_queue
	import sfr_pkg::*;
#(
	parameter int DEPTH = FQ_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  frame_entry_t push_data,
	output logic         full,
	input  logic         pop,
	output frame_entry_t head,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	frame_entry_t     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SFR_ASSERT_NOW(a_no_push_when_full, push, !full)
	`SFR_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CNT_W'(DEPTH))

endmodule

@@ sv/sfr_front.sv @@
`include "assert_macros.svh"

module sfr_front
	import sfr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  in_item_t     in_item,
	input  logic         wr_en,
	input  logic         wr_index,
	input  logic [7:0]   wr_data,
	output logic         q_push,
	output frame_entry_t q_entry
);

	localparam logic [4:0] END_POS = 5'(FRAME_BYTES - 1);

	logic [7:0]              timeout_q;
	logic                    en_q;
	logic [4:0]              pos_q;
	logic [31:0]             prev_q, time_q, good_q, lost_q, err_q;
	logic                    fs_q;
	logic [HOLD_BYTES*8-1:0] fr_q;

	logic [31:0] gap;
	logic [4:0]  pos_eff;
	logic        restart, hunting, at_end, work, done;
	logic [7:0]  flags;
	logic        end_ok, is_lost;
	logic [31:0] time_nx, good_nx, lost_nx, err_nx;
	logic        fs_nx;

	always_comb begin
		gap     = in_item.now_ms - prev_q;
		restart = (gap >= {24'd0, timeout_q});
		pos_eff = restart ? 5'd0 : pos_q;
		hunting = (pos_eff == 5'd0) && (in_item.rx_byte != START_BYTE);
		at_end  = (pos_eff == END_POS);
		work    = take && en_q;
		done    = work && !hunting && at_end;

		flags   = fr_q[HOLD_BYTES*8-1 -: 8];
		end_ok  = (in_item.rx_byte == END_BYTE);
		is_lost = flags[2];

		time_nx = end_ok ? in_item.now_ms : time_q;
		fs_nx   = end_ok ? flags[3] : fs_q;
		err_nx  = end_ok ? err_q : err_q + 32'd1;
		lost_nx = (end_ok && is_lost) ? lost_q + 32'd1 : lost_q;
		good_nx = (end_ok && !is_lost) ? good_q + 32'd1 : good_q;

		q_push             = done;
		q_entry.kind       = !end_ok ? KIND_END_ERR : (is_lost ? KIND_LOST : KIND_CHAN);
		q_entry.failsafe   = fs_nx;
		q_entry.frame_time = time_nx;
		q_entry.good       = good_nx;
		q_entry.lost       = lost_nx;
		q_entry.err        = err_nx;
		// bytes 1..22, little-endian, channel 0 in the low bits
		q_entry.chan_bits  = fr_q[8 +: CHAN_BITS];
		q_entry.digital    = flags[1:0];
	end

	// Frame bytes 0..23 shift in from the top; no reset needed.
	always_ff @(posedge clk) begin
		if (work && !hunting) begin
			fr_q <= {in_item.rx_byte, fr_q[HOLD_BYTES*8-1:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= GAP_RESET;
			en_q      <= 1'b1;
			pos_q     <= '0;
			prev_q    <= '0;
			time_q    <= '0;
			fs_q      <= 1'b1;
			good_q    <= '0;
			lost_q    <= '0;
			err_q     <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_GAP_TIMEOUT: begin
						timeout_q <= wr_data;
					end
					REG_RX_ENABLE: begin
						en_q <= wr_data[0];
					end
					default: begin
					end
				endcase
			end
			if (work) begin
				prev_q <= in_item.now_ms;
				if (hunting || at_end) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_eff + 5'd1;
				end
				if (done) begin
					time_q <= time_nx;
					fs_q   <= fs_nx;
					good_q <= good_nx;
					lost_q <= lost_nx;
					err_q  <= err_nx;
				end
			end
		end
	end

	`SFR_ASSERT_NOW(a_pos_in_frame, 1'b1, pos_q < 5'(FRAME_BYTES))
	`SFR_ASSERT_NEXT(a_done_restarts, done, pos_q == 5'd0)

endmodule

@@ sv/sfr_back.sv @@
`include "assert_macros.svh"

module sfr_back
	import sfr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  frame_entry_t q_head,
	input  logic         q_empty,
	output logic         q_pop,
	output result_t      result,
	output logic         empty,
	input  logic         pop
);

	localparam logic [4:0] CH_LAST  = 5'(CHANNEL_COUNT - 1);
	localparam logic [4:0] CH_DIG_A = 5'(ANALOG_CH);

	logic                 active_q;
	frame_entry_t         cur_q;
	logic [CHAN_BITS-1:0] bits_q;
	logic [4:0]           ch_q;
	logic                 out_valid_q;
	result_t              out_q;

	logic        step, is_last, load;
	logic [10:0] raw;
	logic [13:0] prod;
	logic [11:0] scaled;
	result_t     res_nx;

	always_comb begin
		step    = active_q && (!out_valid_q || pop);
		is_last = (cur_q.kind != KIND_CHAN) || (ch_q == CH_LAST);
		load    = (!active_q || (step && is_last)) && !q_empty;
		q_pop   = load;

		if (ch_q < CH_DIG_A) begin
			raw = bits_q[RAW_W-1:0];
		end else if (ch_q == CH_DIG_A) begin
			raw = cur_q.digital[0] ? DIGITAL_ON : 11'd0;
		end else begin
			raw = cur_q.digital[1] ? DIGITAL_ON : 11'd0;
		end
		prod   = {3'd0, raw} + {1'b0, raw, 2'd0};
		scaled = {1'b0, prod[13:3]} + VALUE_OFFSET;

		res_nx.kind          = cur_q.kind;
		res_nx.channel_index = (cur_q.kind == KIND_CHAN) ? ch_q : 5'd0;
		res_nx.value         = (cur_q.kind == KIND_CHAN) ? scaled : 12'd0;
		res_nx.failsafe      = cur_q.failsafe;
		res_nx.last          = is_last;
		res_nx.frame_time_ms = cur_q.frame_time;
		res_nx.good_frames   = cur_q.good;
		res_nx.lost_frames   = cur_q.lost;
		res_nx.error_frames  = cur_q.err;
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q  <= q_head;
			bits_q <= q_head.chan_bits;
		end else if (step) begin
			bits_q <= bits_q >> RAW_W;
		end
		if (step) begin
			out_q <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
				ch_q     <= '0;
			end else if (step && is_last) begin
				active_q <= 1'b0;
			end else if (step) begin
				ch_q <= ch_q + 5'd1;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SFR_ASSERT_NOW(a_status_single, active_q && cur_q.kind != KIND_CHAN, ch_q == 5'd0)
	`SFR_ASSERT_NOW(a_ch_bound, active_q, ch_q <= CH_LAST)

endmodule

@@ test/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	typedef logic [7:0] frame_bytes_t [FRAME_BYTES];

	// Tracks the receiver state and holds the results it should produce, oldest first.
	class frame_tracker;
		logic [7:0]  timeout_ms;
		logic        rx_on;
		logic [7:0]  held [FRAME_BYTES];
		int unsigned pos;
		logic [31:0] prev_ms;
		logic [31:0] frame_ms;
		logic        fs;
		logic [31:0] good_n;
		logic [31:0] lost_n;
		logic [31:0] err_n;
		result_t     pending_results [$];
		int          faults;

		function new();
			timeout_ms    = GAP_RESET;
			rx_on         = 1'b1;
			pos           = 0;
			prev_ms       = '0;
			frame_ms      = '0;
			fs            = 1'b1;
			good_n        = '0;
			lost_n        = '0;
			err_n         = '0;
			faults        = 0;
		endfunction

		function void write_reg(logic idx, logic [7:0] data);
			if (idx == REG_GAP_TIMEOUT) begin
				timeout_ms = data;
			end else begin
				rx_on = data[0];
			end
		endfunction

		function void queue_result(logic [1:0] kind, logic [4:0] idx, logic [11:0] val,
				logic fin);
			result_t r;
			r.kind          = kind;
			r.channel_index = idx;
			r.value         = val;
			r.failsafe      = fs;
			r.last          = fin;
			r.frame_time_ms = frame_ms;
			r.good_frames   = good_n;
			r.lost_frames   = lost_n;
			r.error_frames  = err_n;
			pending_results.push_back(r);
		endfunction

		// One accepted byte: update the state, queue whatever it completes.
		function void take_byte(in_item_t it);
			logic [CHAN_BITS-1:0] chan_bits;
			logic [10:0]          raw;
			int                   scaled;
			if (!rx_on)
				return;
			if (it.now_ms - prev_ms >= {24'd0, timeout_ms})
				pos = 0;
			prev_ms = it.now_ms;
			if (pos == 0 && it.rx_byte != START_BYTE)
				return;
			held[pos] = it.rx_byte;
			pos++;
			if (pos < FRAME_BYTES)
				return;
			pos = 0;
			if (held[FRAME_BYTES-1] != END_BYTE) begin
				err_n++;
				queue_result(KIND_END_ERR, '0, '0, 1'b1);
				return;
			end
			frame_ms = it.now_ms;
			fs       = held[23][3];
			if (held[23][2]) begin
				lost_n++;
				queue_result(KIND_LOST, '0, '0, 1'b1);
				return;
			end
			good_n++;
			for (int i = 1; i <= 22; i++)
				chan_bits[8*(i-1) +: 8] = held[i];
			for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
				if (ch < ANALOG_CH)
					raw = chan_bits[RAW_W*ch +: RAW_W];
				else
					raw = held[23][ch-ANALOG_CH] ? DIGITAL_ON : 11'd0;
				scaled = ((5 * int'(raw)) >> 3) + int'(VALUE_OFFSET);
				queue_result(KIND_CHAN, 5'(ch), 12'(scaled), ch == CHANNEL_COUNT - 1);
			end
		endfunction

		function void cmp(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				faults++;
			end
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected (kind %0d)", got.kind);
				faults++;
				return;
			end
			want = pending_results.pop_front();
			cmp("kind",          want.kind,          got.kind);
			cmp("channel_index", want.channel_index, got.channel_index);
			cmp("value",         want.value,         got.value);
			cmp("failsafe",      want.failsafe,      got.failsafe);
			cmp("last",          want.last,          got.last);
			cmp("frame_time_ms", want.frame_time_ms, got.frame_time_ms);
			cmp("good_frames",   want.good_frames,   got.good_frames);
			cmp("lost_frames",   want.lost_frames,   got.lost_frames);
			cmp("error_frames",  want.error_frames,  got.error_frames);
		endfunction
	endclass

	// DUT hookup; every input starts at a known value
	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       push     = 1'b0;
	logic       full;
	in_item_t   in_item  = '0;
	logic       empty;
	logic       pop      = 1'b0;
	result_t    result;
	logic       wr_en    = 1'b0;
	logic       wr_index = 1'b0;
	logic [7:0] wr_data  = '0;

	frame_tracker tracker = new();

	logic [31:0] wall_ms = '0;  // running millisecond clock fed to now_ms
	logic        steady  = 1'b0; // when set, neither side inserts gaps
	int          fed     = 0;    // enabled bytes sent in the random part

	sbus_frame_receiver_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #6 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// fill: 0 all zero, 1 all ones, else random channel bytes
	function automatic frame_bytes_t build_frame(int fill, logic [7:0] flags,
			logic [7:0] tail);
		frame_bytes_t f;
		f[0] = START_BYTE;
		for (int i = 1; i <= 22; i++)
			f[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
		f[23] = flags;
		f[24] = tail;
		return f;
	endfunction

	// One input transaction. push stays high into the next call when there
	// is no gap, so it is never dropped and raised in the same step.
	task automatic send_byte(logic [7:0] b, logic [31:0] stamp);
		int gap;
		in_item_t it;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.rx_byte = b;
		it.now_ms  = stamp;
		push    <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (tracker.rx_on)
			fed++;
		tracker.take_byte(it);
	endtask

	// First byte lands lead ms after the last one, the rest step_lo..step_hi apart.
	task automatic send_frame(frame_bytes_t f, int n, int lead, int step_lo, int step_hi);
		for (int i = 0; i < n; i++) begin
			wall_ms += (i == 0) ? lead : $urandom_range(step_lo, step_hi);
			send_byte(f[i], wall_ms);
		end
	endtask

	// Sender pauses until every expected result is out, then still waits for
	// the pipeline to drain (a byte may cause nothing).
	task automatic settle();
		push <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_reg(logic idx, logic [7:0] data);
		settle();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		tracker.write_reg(idx, data);
	endtask

	// Random stimulus: mostly whole frames with random content, the rest
	// truncated frames and loose noise bytes.
	task automatic random_burst();
		frame_bytes_t f;
		logic [7:0]   flags;
		logic [7:0]   tail;
		int           t;
		int           lead;
		int           pick;
		t    = tracker.timeout_ms;
		pick = $urandom_range(0, 99);
		// either a gap that restarts assembly or one that keeps it going
		lead = ($urandom_range(0, 9) < 4) ? t + $urandom_range(0, 10) : $urandom_range(0, t - 1);
		if (pick < 70) begin
			flags    = 8'($urandom);
			flags[2] = ($urandom_range(0, 4) == 0);
			tail     = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : END_BYTE;
			f = build_frame(2, flags, tail);
			send_frame(f, FRAME_BYTES, lead, 0, t - 1);
		end else if (pick < 85) begin
			f = build_frame(2, 8'($urandom), 8'($urandom));
			send_frame(f, $urandom_range(1, FRAME_BYTES - 1), lead, 0, t - 1);
		end else begin
			repeat ($urandom_range(1, 8)) begin
				wall_ms += $urandom_range(0, t + 2);
				send_byte(8'($urandom), wall_ms);
			end
		end
	endtask

	// Result side: check every popped transaction, stall pop at random.
	initial begin
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				tracker.match_result(result);
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				hold = pick_gap();
				pop <= (hold == 0);
			end
		end
	end

	// Main sequence
	initial begin
		int phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// hunting: anything but the start byte at position zero is dropped
		wall_ms = 32'd100;
		send_byte(8'h00, wall_ms);
		send_byte(8'hFF, wall_ms + 1);
		send_byte(8'h55, wall_ms + 2);
		wall_ms += 2;
		// full-scale channels, both digital bits on, failsafe clear
		send_frame(build_frame(1, 8'h03, END_BYTE), FRAME_BYTES, 5, 0, 0);
		// zero channels, failsafe set; lead gap exactly equals the timeout
		send_frame(build_frame(0, 8'h08, END_BYTE), FRAME_BYTES, 3, 2, 2);
		// bad end byte
		send_frame(build_frame(2, 8'h00, 8'hFF), FRAME_BYTES, 4, 0, 1);
		// lost flag with failsafe
		send_frame(build_frame(2, 8'h0C, END_BYTE), FRAME_BYTES, 4, 0, 1);
		// frame cut short by a gap; the next frame restarts over it
		send_frame(build_frame(2, 8'h00, END_BYTE), 10, 4, 0, 1);
		// millisecond clock wraps in the middle of a frame
		wall_ms = 32'hFFFF_FFF0;
		send_frame(build_frame(2, 8'h01, END_BYTE), FRAME_BYTES, 0, 1, 1);

		// zero timeout: every byte restarts, nothing completes
		set_reg(REG_GAP_TIMEOUT, 8'd0);
		send_frame(build_frame(2, 8'h00, END_BYTE), 6, 1, 0, 1);
		// widest timeout with near-limit gaps between bytes
		set_reg(REG_GAP_TIMEOUT, 8'd255);
		send_frame(build_frame(2, 8'h00, END_BYTE), FRAME_BYTES, 300, 254, 254);
		// receiver off: bytes ignored, previous time left alone
		set_reg(REG_RX_ENABLE, 8'd0);
		send_frame(build_frame(2, 8'h00, END_BYTE), 6, 1, 0, 1);
		set_reg(REG_RX_ENABLE, 8'd1);
		send_frame(build_frame(2, 8'h00, END_BYTE), FRAME_BYTES, 1, 0, 1);

		// random part, cycling through timeout settings
		fed   = 0;
		phase = 0;
		wall_ms = $urandom;
		while (fed < 40) begin
			case (phase % 4)
				0: set_reg(REG_GAP_TIMEOUT, GAP_RESET);
				1: set_reg(REG_GAP_TIMEOUT, 8'($urandom_range(1, 20)));
				2: set_reg(REG_GAP_TIMEOUT, 8'd255);
				default: set_reg(REG_GAP_TIMEOUT, 8'($urandom_range(1, 255)));
			endcase
			steady = (phase % 2 == 0);
			repeat (2) random_burst();
			phase++;
		end
		steady = 1'b0;

		settle();
		if (tracker.faults == 0 && tracker.pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/sfr_pkg.sv
sv/sfr_queue.sv
sv/sfr_front.sv
sv/sfr_back.sv
sv/sbus_frame_receiver_unit.sv
test/testbench.sv
